// File: design/lfu_pkg.sv
`default_nettype none
package lfu_pkg;
    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int KEY_W          = 32;
    localparam int VAL_W          = 32;
    localparam int CAP_W          = 5;
    localparam logic CMD_GET      = 1'b0;
    localparam logic CMD_PUT      = 1'b1;

    // Per-cell broadcast from the controller.
    typedef struct packed {
        logic              lookup;   // compare key, report match
        logic              do_hit;   // apply hit to matching cell
        logic              do_ins;   // install into the cell with sel_ins
        logic              is_put;
        logic              age_all;  // age every valid entry (free-slot insert)
    } lfu_ctl_t;
endpackage
`default_nettype wire

// File: design/lfu_if.sv
`default_nettype none
interface lfu_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] key;
    logic [31:0] value;
    modport source (output valid, cmd, key, value, input ready);
    modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface lfu_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] read_value;
    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lfu_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// File: design/lfu_cell.sv
`default_nettype none
module lfu_cell
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int RANK_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lfu_ctl_t              ctl,
    input  wire logic [KEY_W-1:0]      key,
    input  wire logic [VAL_W-1:0]      value,
    input  wire logic                  sel_ins,
    input  wire logic [RANK_W-1:0]     old_rank,
    output logic                       match,
    output logic                       valid,
    output logic [VAL_W-1:0]           val_out,
    output logic [COUNT_BITS-1:0]      count,
    output logic [RANK_W-1:0]          rank
);
    logic                  valid_reg, valid_next;
    logic [KEY_W-1:0]      key_reg;
    logic [VAL_W-1:0]      val_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic                  match_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (ctl.lookup) begin
                match_reg <= valid_reg && (key_reg == key);
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (ctl.do_ins && sel_ins) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (ctl.do_hit && match_reg) begin
            if (ctl.is_put) begin
                val_reg <= value;
            end
            if (cnt_reg != {COUNT_BITS{1'b1}}) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            rank_reg <= '0;
        end else if (ctl.do_ins && sel_ins) begin
            key_reg  <= key;
            val_reg  <= value;
            cnt_reg  <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
            rank_reg <= '0;
        end else if ((ctl.do_hit || ctl.do_ins) && valid_reg &&
                     (ctl.age_all || rank_reg < old_rank)) begin
            rank_reg <= rank_reg + 1'b1;
        end
    end

    assign match   = match_reg;
    assign valid   = valid_reg;
    assign val_out = val_reg;
    assign count   = cnt_reg;
    assign rank    = rank_reg;
endmodule
`default_nettype wire

// File: design/lfu_cache_lru_tiebreak.sv
`default_nettype none
// Channel | Dir | Payload                     | Handshake
// in_ch   | in  | cmd, key, value             | valid/ready
// out_ch  | out | hit, read_value             | valid/ready
// cfg_ch  | in  | data (capacity, 5 bits)     | valid/ready
// An item runs through compare, decide, update and output, and the block takes
// the next beat only once it is back in its idle state. The result is offered in the
// output state after the update step; a get, a put hit or a put into a free entry
// goes from decide straight to update.
// A put miss with no free entry within capacity adds a victim scan that walks the
// cell row one entry per cycle before the update.
// Reset clears all valid bits, occupancy and capacity to its reset value.
// A result waits in the output register; the input stays closed until taken.
module lfu_cache_lru_tiebreak
    import lfu_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lfu_in_if.sink      in_ch,
    lfu_out_if.source   out_ch,
    lfu_cfg_if.sink     cfg_ch
);
    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int SCN_W  = $clog2(ENTRIES + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOOK = 3'd1;
    localparam logic [2:0] ST_DEC  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic               cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;
    logic               hit_reg;
    logic [VAL_W-1:0]   rd_reg;
    logic [SCN_W-1:0]   scan_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic               slot_ok_reg;
    logic               age_reg;
    logic [RANK_W-1:0]  orank_reg;
    logic               upd_hit_reg;
    logic               upd_ins_reg;

    lfu_ctl_t                         ctl;
    logic [ENTRIES-1:0]               match, valid, sel;
    logic [VAL_W-1:0]                 vals  [ENTRIES];
    logic [COUNT_BITS-1:0]            cnts  [ENTRIES];
    logic [RANK_W-1:0]                ranks [ENTRIES];

    // Effective capacity is the configured one clipped to the built size.
    logic [OCC_W:0] cap_eff;
    assign cap_eff = ({{(OCC_W+1){1'b0}}, cap_reg} > (OCC_W+1+CAP_W)'(ENTRIES))
                     ? (OCC_W+1)'(ENTRIES) : (OCC_W+1)'(cap_reg);

    // Hit value, hit rank and free slot: one-hot mux and priority search over the row.
    logic [VAL_W-1:0]  hit_val;
    logic [RANK_W-1:0] hit_rank;
    logic              any_match;
    logic [IDX_W-1:0]  free_idx;
    logic              free_ok;
    always_comb begin
        hit_val   = '0;
        hit_rank  = '0;
        any_match = 1'b0;
        free_idx  = '0;
        free_ok   = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_val   = vals[i];
                hit_rank  = ranks[i];
                any_match = 1'b1;
            end
            if (!valid[i]) begin
                free_idx = IDX_W'(i);
                free_ok  = 1'b1;
            end
        end
    end

    // The scan visits one cell per cycle.
    logic [IDX_W-1:0]      scan_idx;
    logic                  better;
    assign scan_idx = scan_reg[IDX_W-1:0];
    assign better = valid[scan_idx] && (!slot_ok_reg ||
                    cnts[scan_idx] < cnts[slot_reg] ||
                    (cnts[scan_idx] == cnts[slot_reg] &&
                     ranks[scan_idx] > ranks[slot_reg]));

    always_comb begin
        ctl         = '0;
        ctl.lookup  = (state_reg == ST_LOOK);
        ctl.do_hit  = (state_reg == ST_UPD) && upd_hit_reg;
        ctl.do_ins  = (state_reg == ST_UPD) && upd_ins_reg;
        ctl.is_put  = cmd_reg;
        ctl.age_all = age_reg;
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            sel[i] = (slot_reg == IDX_W'(i));
        end
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .key      (key_reg),
            .value    (val_reg),
            .sel_ins  (sel[g]),
            .old_rank (orank_reg),
            .match    (match[g]),
            .valid    (valid[g]),
            .val_out  (vals[g]),
            .count    (cnts[g]),
            .rank     (ranks[g])
        );
    end

    assign in_ch.ready   = (state_reg == ST_IDLE);
    assign cfg_ch.ready  = 1'b1;
    assign out_ch.valid  = (state_reg == ST_OUT);
    assign out_ch.hit    = hit_reg;
    assign out_ch.read_value = rd_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_ch.valid) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_DEC;
            ST_DEC: begin
                if (cmd_reg == CMD_GET || any_match || cap_eff == '0) begin
                    state_next = ST_UPD;
                end else if ((OCC_W+1)'(occ_reg) < cap_eff && free_ok) begin
                    state_next = ST_UPD;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: if (scan_reg == SCN_W'(ENTRIES - 1)) state_next = ST_UPD;
            ST_UPD:  state_next = ST_OUT;
            ST_OUT:  if (out_ch.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_W'(16);
            occ_reg     <= '0;
            upd_hit_reg <= 1'b0;
            upd_ins_reg <= 1'b0;
            slot_ok_reg <= 1'b0;
            age_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_ch.valid) begin
                cap_reg <= cfg_ch.data;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    upd_hit_reg <= 1'b0;
                    upd_ins_reg <= 1'b0;
                    slot_ok_reg <= 1'b0;
                    age_reg     <= 1'b0;
                end
                ST_DEC: begin
                    if (cmd_reg == CMD_GET) begin
                        upd_hit_reg <= any_match;
                    end else if (cap_eff == '0) begin
                        upd_hit_reg <= 1'b0;
                    end else if (any_match) begin
                        upd_hit_reg <= 1'b1;
                    end else if ((OCC_W+1)'(occ_reg) < cap_eff && free_ok) begin
                        upd_ins_reg <= 1'b1;
                        age_reg     <= 1'b1;
                        occ_reg     <= occ_reg + 1'b1;
                    end else begin
                        upd_ins_reg <= 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (better) slot_ok_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Payload and scan datapath.
    always_ff @(posedge clk) begin
        if (in_ch.valid && in_ch.ready) begin
            cmd_reg  <= in_ch.cmd;
            key_reg  <= in_ch.key;
            val_reg  <= in_ch.value;
            scan_reg <= '0;
        end
        if (state_reg == ST_DEC) begin
            hit_reg   <= any_match;
            rd_reg    <= (cmd_reg == CMD_PUT) ? '0 : (any_match ? hit_val : '1);
            slot_reg  <= free_idx;
            orank_reg <= hit_rank;
        end
        if (state_reg == ST_SCAN) begin
            scan_reg <= scan_reg + 1'b1;
            if (better) begin
                slot_reg  <= scan_idx;
                orank_reg <= ranks[scan_idx];
            end
        end
    end

    // At most one cell holds a given key.
    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DEC |-> $onehot0(match))
        else $error("multiple cells matched one key");
    // Occupancy equals the number of valid cells.
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> $countones(valid) == int'(occ_reg))
        else $error("occupancy out of step with valid bits");
    // A result is presented in the cycle after the update step.
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD |=> out_ch.valid)
        else $error("result not presented after update");
endmodule
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import lfu_pkg::*;

    localparam int NSLOT = ENTRIES_DEF;
    localparam int CNT_MAX = (1 << COUNT_BITS_DEF) - 1;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
    } lookup_result_t;

    logic clk;
    logic rst_n;

    lfu_in_if  in_ch ();
    lfu_out_if out_ch ();
    lfu_cfg_if cfg_ch ();

    lfu_cache_lru_tiebreak dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // The predictor's own copy of the cache contents and capacity.
    logic [4:0]  cap_reg;
    logic        slot_valid [NSLOT];
    logic [31:0] slot_key   [NSLOT];
    logic [31:0] slot_value [NSLOT];
    int unsigned slot_count [NSLOT];
    int unsigned slot_age   [NSLOT];
    int unsigned held;

    lookup_result_t pending_results[$];
    int error_count;
    int idle_cycles;
    bit timed_out;

    // Keys are mostly drawn from a small pool so hits, updates and evictions are common;
    // the pool holds the extreme values too.
    logic [31:0] key_pool[24];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Move slot s to the most recent position; entries newer than old_age get older.
    function automatic void make_newest(int s, int unsigned old_age);
        for (int i = 0; i < NSLOT; i++)
            if (slot_valid[i] && i != s && slot_age[i] < old_age)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function automatic lookup_result_t cache_access(logic cmd, logic [31:0] key,
                                                    logic [31:0] val);
        lookup_result_t r;
        int found;
        int slot;
        int unsigned lim;
        int unsigned old_age;
        found = -1;
        slot = -1;
        lim = (cap_reg > NSLOT) ? NSLOT : cap_reg;
        for (int i = 0; i < NSLOT; i++)
            if (found < 0 && slot_valid[i] && slot_key[i] == key)
                found = i;
        r.hit = (found >= 0);
        r.read_value = '0;
        if (cmd == CMD_GET)
        begin
            if (found < 0)
                r.read_value = '1;
            else
            begin
                r.read_value = slot_value[found];
                if (slot_count[found] < CNT_MAX)
                    slot_count[found]++;
                make_newest(found, slot_age[found]);
            end
            return r;
        end
        // A put with zero capacity leaves the cache untouched.
        if (lim == 0)
            return r;
        if (found >= 0)
        begin
            slot_value[found] = val;
            if (slot_count[found] < CNT_MAX)
                slot_count[found]++;
            make_newest(found, slot_age[found]);
            return r;
        end
        if (held < lim)
            for (int i = 0; i < NSLOT; i++)
                if (slot < 0 && !slot_valid[i])
                    slot = i;
        if (slot >= 0)
        begin
            held++;
            old_age = held;
        end
        else
        begin
            // Victim: lowest count, and among equal counts the oldest access.
            for (int i = 0; i < NSLOT; i++)
                if (slot_valid[i] && (slot < 0 || slot_count[i] < slot_count[slot] ||
                    (slot_count[i] == slot_count[slot] && slot_age[i] > slot_age[slot])))
                    slot = i;
            if (slot < 0)
                return r;
            old_age = slot_age[slot];
        end
        slot_valid[slot] = 1'b1;
        slot_key[slot] = key;
        slot_value[slot] = val;
        slot_count[slot] = 1;
        make_newest(slot, old_age);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Random pause before a beat: mostly short, sometimes none, rarely long.
    task automatic random_gap();
        int n;
        int p;
        p = $urandom_range(99);
        if (p < 45)
            n = 0;
        else if (p < 92)
            n = $urandom_range(3, 1);
        else
            n = $urandom_range(40, 10);
        repeat (n) @(negedge clk);
    endtask

    task automatic send_beat(logic cmd, logic [31:0] key, logic [31:0] val);
        random_gap();
        in_ch.valid = 1'b1;
        in_ch.cmd   = cmd;
        in_ch.key   = key;
        in_ch.value = val;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_results.push_back(cache_access(cmd, key, val));
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0 && !timed_out)
            @(negedge clk);
        // Let the block settle back to idle before the next step.
        repeat (30) @(negedge clk);
    endtask

    // Capacity is written only with nothing in flight.
    task automatic write_capacity(logic [4:0] cap);
        wait_drained();
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = cap;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cap_reg = cap;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(9) == 0)
            return $urandom;
        return key_pool[$urandom_range(23)];
    endfunction

    task automatic test_directed();
        // Misses on an empty cache, then fill with the extreme keys and values.
        send_beat(CMD_GET, 32'h8000_0000, '0);
        send_beat(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_beat(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_beat(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_beat(CMD_GET, 32'hFFFF_FFFF, '0);
        send_beat(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
        send_beat(CMD_GET, 32'h0000_0000, '0);
        // Capacity two: new puts evict the entry with the lowest count.
        write_capacity(5'd2);
        send_beat(CMD_PUT, 32'h0000_0011, 32'h0000_0001);
        send_beat(CMD_PUT, 32'h0000_0022, 32'h0000_0002);
        send_beat(CMD_GET, 32'h0000_0011, '0);
        send_beat(CMD_PUT, 32'h0000_0033, 32'h0000_0003);
        send_beat(CMD_GET, 32'h0000_0011, '0);
        // Zero capacity: puts change nothing but hits are still reported.
        write_capacity(5'd0);
        send_beat(CMD_PUT, 32'h0000_0044, 32'h0000_0004);
        send_beat(CMD_GET, 32'h0000_0044, '0);
        send_beat(CMD_PUT, 32'h8000_0000, 32'h5555_5555);
        send_beat(CMD_GET, 32'h8000_0000, '0);
        write_capacity(5'd31);
        send_beat(CMD_PUT, 32'h0000_0044, 32'hAAAA_AAAA);
    endtask

    task automatic test_saturation();
        write_capacity(5'd16);
        // Give one key a high count; it must then survive evictions.
        for (int i = 0; i < 100; i++)
            send_beat(CMD_GET, 32'h8000_0000, '0);
        for (int i = 0; i < 20; i++)
            send_beat(CMD_PUT, 32'h0BAD_0000 + i, $urandom);
        send_beat(CMD_GET, 32'h8000_0000, '0);
    endtask

    task automatic test_random(int items);
        logic [4:0] caps[8];
        caps = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd17, 5'd8, 5'd31, 5'd3};
        for (int phase = 0; phase < 8; phase++)
        begin
            write_capacity(caps[phase]);
            for (int i = 0; i < items / 8; i++)
            begin
                send_beat(($urandom_range(99) < 55) ? CMD_PUT : CMD_GET,
                          pick_key(), $urandom);
                if (i == items / 16)
                    wait_drained();
            end
        end
    endtask

    // Result checker and sink-side stalls.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(99) < 70)
                out_ch.ready <= 1'b1;
            else
            begin
                out_ch.ready <= 1'b0;
                if ($urandom_range(19) == 0)
                    repeat ($urandom_range(30, 5)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", out_ch.read_value, '0);
            end
            else
            begin
                lookup_result_t w;
                w = pending_results.pop_front();
                if (out_ch.hit !== w.hit)
                    report_mismatch("hit", {31'b0, out_ch.hit}, {31'b0, w.hit});
                if (out_ch.read_value !== w.read_value)
                    report_mismatch("read_value", out_ch.read_value, w.read_value);
            end
        end
    end

    // Watchdog: counts cycles with no beat on any channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        idle_cycles = 0;
        timed_out = 1'b0;
        error_count = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_GET;
        in_ch.key = '0;
        in_ch.value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        cap_reg = 5'd16;
        held = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_key[i] = '0;
            slot_value[i] = '0;
            slot_count[i] = 0;
            slot_age[i] = 0;
        end
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 24; i++)
            key_pool[i] = $urandom;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_saturation();
        test_random(1600);

        wait_drained();
        if (error_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
